FILE: sv/ardc_pkg.sv
// ----------------------------------------------------------------------------
// Audio rate divider checker: shared package
// Rate table, register indexes and the request and response types of the
// shared restoring divider.
// ----------------------------------------------------------------------------
package ardc_pkg;

  localparam int TABLE_LEN = 12;
  localparam int TBL_IDX_W = 4;
  localparam int RATE_W    = 21;
  localparam int REQ_W     = 22;
  localparam int CLK_W     = 31;
  localparam int CH_W      = 4;
  localparam int FB_W      = 7;
  localparam int PPM_W     = 20;
  localparam int FC_W      = FB_W + CH_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 31;

  // Divider geometry: a 52-bit dividend, left aligned, over a 32-bit divisor.
  localparam int DVD_W = 52;
  localparam int DVS_W = 32;
  localparam int CNT_W = 6;

  localparam logic [PPM_W-1:0] PPM_SCALE = 20'd1000000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERROR = 3'd4;

  localparam logic [CLK_W-1:0] CLOCK_A_RST   = 31'd22579200;
  localparam logic [CLK_W-1:0] CLOCK_B_RST   = 31'd24576000;
  localparam logic [CH_W-1:0]  CHANNELS_RST  = 4'd2;
  localparam logic [FB_W-1:0]  FRAME_RST     = 7'd32;
  localparam logic [PPM_W-1:0] MAX_ERROR_RST = 20'd1000;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  // Even entries are the 44.1 kHz family, odd entries the 48 kHz family.
  function automatic logic [RATE_W-1:0] rate_at(input logic [TBL_IDX_W-1:0] idx);
    logic [RATE_W-1:0] r;
    unique case (idx)
      4'd0:    r = 21'd44100;
      4'd1:    r = 21'd48000;
      4'd2:    r = 21'd88200;
      4'd3:    r = 21'd96000;
      4'd4:    r = 21'd176400;
      4'd5:    r = 21'd192000;
      4'd6:    r = 21'd352800;
      4'd7:    r = 21'd384000;
      4'd8:    r = 21'd705600;
      4'd9:    r = 21'd768000;
      4'd10:   r = 21'd1411200;
      4'd11:   r = 21'd1536000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/ardc_req_if.sv
// ----------------------------------------------------------------------------
// Audio rate divider checker: request channel
// Valid/ready channel that carries the requested sample-rate interval.
// ----------------------------------------------------------------------------
interface ardc_req_if;
  logic                           valid;
  logic                           ready;
  logic [ardc_pkg::REQ_W-1:0]     req_min_rate;
  logic [ardc_pkg::REQ_W-1:0]     req_max_rate;

  modport source (output valid, output req_min_rate, output req_max_rate, input ready);
  modport sink   (input valid, input req_min_rate, input req_max_rate, output ready);
endinterface

FILE: sv/ardc_rsp_if.sv
// ----------------------------------------------------------------------------
// Audio rate divider checker: response channel
// Valid/ready channel that carries the accepted rate range.
// ----------------------------------------------------------------------------
interface ardc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           range_empty;
  logic [ardc_pkg::RATE_W-1:0]    range_min_rate;
  logic [ardc_pkg::RATE_W-1:0]    range_max_rate;

  modport source (output valid, output range_empty, output range_min_rate,
                  output range_max_rate, input ready);
  modport sink   (input valid, input range_empty, input range_min_rate,
                  input range_max_rate, output ready);
endinterface

FILE: sv/ardc_div.sv
// ----------------------------------------------------------------------------
// Audio rate divider checker: shared divider
// Restoring unsigned divider, one quotient bit per cycle. The dividend comes
// left aligned and iters gives the number of significant dividend bits.
// ----------------------------------------------------------------------------
module ardc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ardc_pkg::div_req_t req_i,
  output ardc_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, done_q;
  logic [ardc_pkg::CNT_W-1:0]    cnt_q;
  logic [ardc_pkg::DVD_W-1:0]    dvd_q, quo_q;
  logic [ardc_pkg::DVS_W-1:0]    dvs_q, rem_q;
  logic [ardc_pkg::DVS_W:0]      trial, diff;
  logic                          ge;

  assign trial = {rem_q, dvd_q[ardc_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ardc_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[ardc_pkg::DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[ardc_pkg::DVD_W-2:0], ge};
      // The partial remainder stays below the divisor, so 32 bits hold it.
      rem_q <= ge ? diff[ardc_pkg::DVS_W-1:0] : trial[ardc_pkg::DVS_W-1:0];
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: sv/audio_rate_divider_checker.sv
// ----------------------------------------------------------------------------
// Audio rate divider checker: top level
// Walks the audio rate table for a requested interval and reports the
// smallest and largest rates whose integer clock divider is within tolerance.
// ----------------------------------------------------------------------------
// One request word is worked on at a time and the request channel is not ready
// until its response word is formed. Each table rate inside the interval runs
// through the one shared bit-serial divider: up to three
// 31-bit divisions (divider and the two rounding candidates) and one 52-bit
// division for the ppm remainder term; rates outside the interval are skipped
// in the check state without a division. The
// response word sits in an output register, so a new request is taken while
// an earlier response still waits. Configuration writes apply at once.
module audio_rate_divider_checker #(
  parameter int NUM_RATES = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ardc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ardc_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  ardc_req_if.sink                        req_i,
  ardc_rsp_if.source                      rsp_o
);

  localparam int NUM_EFF = (NUM_RATES < ardc_pkg::TABLE_LEN) ? NUM_RATES
                                                             : ardc_pkg::TABLE_LEN;
  localparam int IDX_W   = $clog2(NUM_EFF + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ZERO  = 4'd3;
  localparam logic [3:0] S_D1    = 4'd4;
  localparam logic [3:0] S_D2    = 4'd5;
  localparam logic [3:0] S_D3    = 4'd6;
  localparam logic [3:0] S_MQ    = 4'd7;
  localparam logic [3:0] S_DQS   = 4'd8;
  localparam logic [3:0] S_DQ    = 4'd9;
  localparam logic [3:0] S_MP    = 4'd10;
  localparam logic [3:0] S_CMP   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam int DVD_W = ardc_pkg::DVD_W;
  localparam int DVS_W = ardc_pkg::DVS_W;
  localparam int CLK_W = ardc_pkg::CLK_W;

  // Configuration registers.
  logic [CLK_W-1:0]              clock_a_q, clock_b_q;
  logic [ardc_pkg::CH_W-1:0]     chan_q;
  logic [ardc_pkg::FB_W-1:0]     frame_q;
  logic [ardc_pkg::PPM_W-1:0]    max_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_a_q <= ardc_pkg::CLOCK_A_RST;
      clock_b_q <= ardc_pkg::CLOCK_B_RST;
      chan_q    <= ardc_pkg::CHANNELS_RST;
      frame_q   <= ardc_pkg::FRAME_RST;
      max_err_q <= ardc_pkg::MAX_ERROR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ardc_pkg::REG_CLOCK_A:   clock_a_q <= cfg_wdata_i[CLK_W-1:0];
        ardc_pkg::REG_CLOCK_B:   clock_b_q <= cfg_wdata_i[CLK_W-1:0];
        ardc_pkg::REG_CHANNELS:  chan_q    <= cfg_wdata_i[ardc_pkg::CH_W-1:0];
        ardc_pkg::REG_FRAME:     frame_q   <= cfg_wdata_i[ardc_pkg::FB_W-1:0];
        ardc_pkg::REG_MAX_ERROR: max_err_q <= cfg_wdata_i[ardc_pkg::PPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and working registers.
  logic [3:0]                    state_q, state_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [ardc_pkg::REQ_W-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [ardc_pkg::FC_W-1:0]     fc_q, fc_d;
  logic [DVS_W-1:0]              bclk_q, bclk_d;
  logic [CLK_W-1:0]              sclk_q, sclk_d;
  logic [DVS_W-1:0]              div_q, div_d;
  logic [DVS_W-1:0]              rem_q, rem_d;
  logic [DVS_W-1:0]              t1_q, t1_d;
  logic                          neg_q, neg_d;
  logic [DVD_W-1:0]              prod_q, prod_d;
  logic [ardc_pkg::PPM_W-1:0]    qmag_q, qmag_d;
  logic                          empty_q, empty_d;
  logic [ardc_pkg::RATE_W-1:0]   rmin_q, rmin_d, rmax_q, rmax_d;

  logic                          rsp_valid_q;
  logic                          rsp_empty_q;
  logic [ardc_pkg::RATE_W-1:0]   rsp_min_q, rsp_max_q;

  logic [ardc_pkg::RATE_W-1:0]   rate;
  logic                          in_range;
  logic [DVS_W-1:0]              t2;
  logic [ardc_pkg::PPM_W-1:0]    mul_a;
  logic [DVS_W-1:0]              mul_b;
  logic [DVD_W-1:0]              mul_p;
  logic [DVS_W:0]                q_plus_div;
  logic                          pass;
  logic                          rsp_load;

  ardc_pkg::div_req_t            div_req;
  ardc_pkg::div_rsp_t            div_rsp;

  ardc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign rate     = ardc_pkg::rate_at(ardc_pkg::TBL_IDX_W'(idx_q));
  assign in_range = !(({1'b0, rate} < lo_q) || ({1'b0, rate} > hi_q));
  assign t2       = bclk_q - div_rsp.quotient[DVS_W-1:0];

  // One multiplier serves the scaled remainder and the scaled limit.
  assign mul_a = (state_q == S_MQ) ? ardc_pkg::PPM_SCALE : max_err_q;
  assign mul_b = (state_q == S_MQ) ? rem_q : div_q;
  assign mul_p = DVD_W'(mul_a) * DVD_W'(mul_b);

  // |ppm| < limit: floor(q/div) < M is q < M*div, ceil(q/div) < M is q+div <= M*div.
  assign q_plus_div = (DVS_W+1)'(qmag_q) + (DVS_W+1)'(div_q);
  assign pass = neg_q ? (DVD_W'(q_plus_div) <= prod_q) : (DVD_W'(qmag_q) < prod_q);

  assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    div_req          = '0;
    div_req.iters    = ardc_pkg::CNT_W'(CLK_W);
    div_req.dividend = {sclk_q, (DVD_W-CLK_W)'(0)};
    unique case (state_q)
      S_ZERO: begin
        div_req.start   = (bclk_q != '0) && (sclk_q != '0);
        div_req.divisor = bclk_q;
      end
      S_D1: begin
        div_req.start   = div_rsp.done && (div_rsp.remainder != '0) &&
                          (div_rsp.quotient != '0);
        div_req.divisor = div_rsp.quotient[DVS_W-1:0];
      end
      S_D2: begin
        div_req.start   = div_rsp.done;
        div_req.divisor = div_q + DVS_W'(1);
      end
      S_DQS: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = bclk_q;
        div_req.iters    = ardc_pkg::CNT_W'(DVD_W);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    fc_d    = fc_q;
    bclk_d  = bclk_q;
    sclk_d  = sclk_q;
    div_d   = div_q;
    rem_d   = rem_q;
    t1_d    = t1_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    qmag_d  = qmag_q;
    empty_d = empty_q;
    rmin_d  = rmin_q;
    rmax_d  = rmax_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          lo_d    = req_i.req_min_rate;
          hi_d    = req_i.req_max_rate;
          fc_d    = ardc_pkg::FC_W'(frame_q) * ardc_pkg::FC_W'(chan_q);
          idx_d   = '0;
          empty_d = 1'b1;
          rmin_d  = '0;
          rmax_d  = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (idx_q == IDX_W'(NUM_EFF)) begin
          state_d = S_DONE;
        end else if (!in_range) begin
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        bclk_d  = DVS_W'(fc_q) * DVS_W'(rate);
        sclk_d  = idx_q[0] ? clock_b_q : clock_a_q;
        state_d = S_ZERO;
      end
      S_ZERO: begin
        if (div_req.start) begin
          state_d = S_D1;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_CHECK;
        end
      end
      S_D1: begin
        if (div_rsp.done) begin
          div_d = div_rsp.quotient[DVS_W-1:0];
          rem_d = div_rsp.remainder;
          neg_d = 1'b0;
          if (div_rsp.remainder == '0) begin
            state_d = S_MQ;
          end else if (div_rsp.quotient == '0) begin
            // Source clock below the bit clock: round up to a divider of one.
            div_d   = DVS_W'(1);
            rem_d   = bclk_q - div_rsp.remainder;
            neg_d   = 1'b1;
            state_d = S_MQ;
          end else begin
            state_d = S_D2;
          end
        end
      end
      S_D2: begin
        if (div_rsp.done) begin
          t1_d    = div_rsp.quotient[DVS_W-1:0] - bclk_q;
          state_d = S_D3;
        end
      end
      S_D3: begin
        if (div_rsp.done) begin
          if (t1_q > t2) begin
            div_d = div_q + DVS_W'(1);
            rem_d = bclk_q - rem_q;
            neg_d = 1'b1;
          end
          state_d = S_MQ;
        end
      end
      S_MQ: begin
        prod_d  = mul_p;
        state_d = S_DQS;
      end
      S_DQS: begin
        state_d = S_DQ;
      end
      S_DQ: begin
        if (div_rsp.done) begin
          qmag_d  = div_rsp.quotient[ardc_pkg::PPM_W-1:0];
          state_d = S_MP;
        end
      end
      S_MP: begin
        prod_d  = mul_p;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (pass) begin
          if (empty_q) begin
            rmin_d = rate;
          end
          empty_d = 1'b0;
          rmax_d  = rate;
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_CHECK;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      empty_q     <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      empty_q <= empty_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    fc_q   <= fc_d;
    bclk_q <= bclk_d;
    sclk_q <= sclk_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    t1_q   <= t1_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    qmag_q <= qmag_d;
    rmin_q <= rmin_d;
    rmax_q <= rmax_d;
    if (rsp_load) begin
      rsp_empty_q <= empty_q;
      rsp_min_q   <= rmin_q;
      rsp_max_q   <= rmax_q;
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.range_empty    = rsp_empty_q;
  assign rsp_o.range_min_rate = rsp_min_q;
  assign rsp_o.range_max_rate = rsp_max_q;

  // The divider is never started on a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with a zero divisor");

  // A new request word is only taken while the divider is quiet.
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (!div_rsp.busy && !div_rsp.done))
    else $error("request accepted while the divider is active");

  // A non-empty response word has its lower rate at or below its upper rate.
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_empty_q) |-> (rsp_min_q <= rsp_max_q))
    else $error("response range inverted");

  // An empty response word carries zero rates.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_empty_q) |-> ((rsp_min_q == '0) && (rsp_max_q == '0)))
    else $error("empty response with nonzero rates");

endmodule
